@@ src/rsi_pkg.sv @@
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared constants for the ray / sphere intersection unit: default formats
// and configuration register indexes.
// ----------------------------------------------------------------------------
package rsi_pkg;

  localparam int COORD_WIDTH   = 32;
  localparam int FRAC_BITS     = 16;
  localparam int EPS_WIDTH     = 16;
  localparam int REG_IDX_WIDTH = 3;

  localparam logic [REG_IDX_WIDTH-1:0] REG_CENTER_X  = 3'd0;
  localparam logic [REG_IDX_WIDTH-1:0] REG_CENTER_Y  = 3'd1;
  localparam logic [REG_IDX_WIDTH-1:0] REG_CENTER_Z  = 3'd2;
  localparam logic [REG_IDX_WIDTH-1:0] REG_RADIUS_SQ = 3'd3;
  localparam logic [REG_IDX_WIDTH-1:0] REG_EPSILON   = 3'd4;

endpackage

@@ src/rsi_quad.sv @@
// ----------------------------------------------------------------------------
// rsi_quad
// Front end: v = o - c, dot products, B and C of the quadratic, B*B from
// partial products, discriminant and the epsilon test. Six stages.
// ----------------------------------------------------------------------------
module rsi_quad #(
  parameter int CW    = rsi_pkg::COORD_WIDTH,
  parameter int FB    = rsi_pkg::FRAC_BITS,
  parameter int DW    = FB + 2,
  parameter int VW    = CW + 1,
  parameter int PDW   = DW + VW,
  parameter int DOTW  = PDW + 2,
  parameter int BW    = DOTW - FB + 1,
  parameter int PVW   = 2 * VW,
  parameter int VVW   = PVW + 2,
  parameter int RW    = 63,
  parameter int CCW   = VVW + 1,
  parameter int H     = (BW + 1) / 2,
  parameter int BBW   = 4 * H,
  parameter int DISCW = BBW + 2
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              adv,
  input  logic                              in_valid,
  input  logic signed [CW-1:0]              org [3],
  input  logic signed [DW-1:0]              dir [3],
  input  logic signed [CW-1:0]              ctr [3],
  input  logic [RW-1:0]                     rsq,
  input  logic [rsi_pkg::EPS_WIDTH-1:0]     eps,
  output logic                              out_valid,
  output logic [DISCW-2:0]                  rad,
  output logic                              miss,
  output logic signed [BW-1:0]              b_out,
  output logic signed [CW-1:0]              org_out [3],
  output logic signed [DW-1:0]              dir_out [3]
);

  localparam int NS = 6;

  logic [NS-1:0]              vld;
  logic signed [CW-1:0]       o_r [NS][3];
  logic signed [DW-1:0]       d_r [NS][3];
  logic signed [VW-1:0]       v1 [3];
  logic signed [PDW-1:0]      pd2 [3];
  logic signed [PVW-1:0]      pv2 [3];
  logic signed [DOTW-1:0]     dot;
  logic signed [VVW-1:0]      vv;
  logic signed [BW-1:0]       b3, b4, b5, b6;
  logic signed [CCW-1:0]      cc3, cc4;
  logic [BW-1:0]              bm;
  logic [2*H-1:0]             bmag;
  logic [2*H-1:0]             hh4, hl4, ll4;
  logic [BBW-1:0]             bb;
  logic signed [DISCW-1:0]    disc, disc5, thr;
  logic [DISCW-2:0]           rad6;
  logic                       miss6;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-2:0], in_valid};
    end
  end

  always_comb begin
    dot  = DOTW'(pd2[0]) + DOTW'(pd2[1]) + DOTW'(pd2[2]);
    vv   = VVW'(pv2[0]) + VVW'(pv2[1]) + VVW'(pv2[2]);
    bm   = b3[BW-1] ? BW'(-b3) : BW'(b3);
    bmag = (2*H)'(bm);
    bb   = (BBW'(hh4) << (2*H)) + (BBW'(hl4) << (H+1)) + BBW'(ll4);
    disc = DISCW'({1'b0, bb}) - (DISCW'(cc4) <<< 2);
    thr  = DISCW'({eps, {FB{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        o_r[0][i] <= org[i];
        d_r[0][i] <= dir[i];
        v1[i]     <= VW'(org[i]) - VW'(ctr[i]);
        pd2[i]    <= d_r[0][i] * v1[i];
        pv2[i]    <= v1[i] * v1[i];
      end
      for (int k = 1; k < NS; k++) begin
        o_r[k] <= o_r[k-1];
        d_r[k] <= d_r[k-1];
      end
      b3    <= BW'(dot >>> (FB-1));
      cc3   <= CCW'(vv) - CCW'(rsq);
      hh4   <= bmag[2*H-1:H] * bmag[2*H-1:H];
      hl4   <= bmag[2*H-1:H] * bmag[H-1:0];
      ll4   <= bmag[H-1:0] * bmag[H-1:0];
      b4    <= b3;
      cc4   <= cc3;
      disc5 <= disc;
      b5    <= b4;
      miss6 <= !(disc5 > thr);
      rad6  <= (disc5 > thr) ? disc5[DISCW-2:0] : '0;
      b6    <= b5;
    end
  end

  assign out_valid = vld[NS-1];
  assign rad       = rad6;
  assign miss      = miss6;
  assign b_out     = b6;
  assign org_out   = o_r[NS-1];
  assign dir_out   = d_r[NS-1];

endmodule

@@ src/rsi_sqrt.sv @@
// ----------------------------------------------------------------------------
// rsi_sqrt
// Pipelined floor square root, one root bit per stage, restoring form.
// A sideband vector travels alongside the radicand.
// ----------------------------------------------------------------------------
module rsi_sqrt #(
  parameter int RDW = 77,
  parameter int SQW = 39,
  parameter int SBW = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            in_valid,
  input  logic [RDW-1:0]  rad,
  input  logic [SBW-1:0]  sb_in,
  output logic            out_valid,
  output logic [SQW-1:0]  root,
  output logic [SBW-1:0]  sb_out
);

  localparam int TRW = RDW + 1;

  logic [SQW-1:0] vld;
  logic [RDW-1:0] rem_r  [SQW];
  logic [SQW-1:0] root_r [SQW];
  logic [SBW-1:0] sb_r   [SQW];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[SQW-2:0], in_valid};
    end
  end

  for (genvar k = 0; k < SQW; k++) begin : g_stage
    localparam int J = SQW - 1 - k;
    logic [RDW-1:0] rem_in;
    logic [SQW-1:0] root_in;
    logic [SBW-1:0] sbi;
    logic [TRW-1:0] trial;
    logic           fit;

    if (k == 0) begin : g_first
      assign rem_in  = rad;
      assign root_in = '0;
      assign sbi     = sb_in;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign sbi     = sb_r[k-1];
    end

    assign trial = (TRW'(root_in) << (J+1)) + (TRW'(1) << (2*J));
    assign fit   = {1'b0, rem_in} >= trial;

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k]  <= fit ? rem_in - trial[RDW-1:0] : rem_in;
        root_r[k] <= fit ? (root_in | (SQW'(1) << J)) : root_in;
        sb_r[k]   <= sbi;
      end
    end
  end

  assign out_valid = vld[SQW-1];
  assign root      = root_r[SQW-1];
  assign sb_out    = sb_r[SQW-1];

endmodule

@@ src/rsi_hit.sv @@
// ----------------------------------------------------------------------------
// rsi_hit
// Back end: roots t0/t1, epsilon tests, hit points o + d*t with saturation,
// nearest-first ordering, output register with a one-entry skid buffer.
// ----------------------------------------------------------------------------
module rsi_hit #(
  parameter int CW  = rsi_pkg::COORD_WIDTH,
  parameter int FB  = rsi_pkg::FRAC_BITS,
  parameter int DW  = FB + 2,
  parameter int BW  = 38,
  parameter int SQW = 39,
  parameter int TW  = 41
) (
  input  logic                           clk,
  input  logic                           rst,
  output logic                           adv,
  input  logic                           in_valid,
  input  logic signed [BW-1:0]           b,
  input  logic [SQW-1:0]                 s,
  input  logic                           miss,
  input  logic signed [CW-1:0]           org [3],
  input  logic signed [DW-1:0]           dir [3],
  input  logic [rsi_pkg::EPS_WIDTH-1:0]  eps,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     cnt,
  output logic [CW-2:0]                  nt,
  output logic signed [CW-1:0]           np [3],
  output logic [CW-2:0]                  ft,
  output logic signed [CW-1:0]           fp [3]
);

  localparam int PTW = DW + TW;
  localparam int HW  = ((PTW - FB > CW) ? PTW - FB : CW) + 1;

  function automatic logic [CW-1:0] sat_c(input logic signed [HW-1:0] q);
    logic fits;
    fits = (q[HW-1:CW-1] == {(HW-CW+1){q[HW-1]}});
    if (fits) return q[CW-1:0];
    return q[HW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
  endfunction

  function automatic logic [CW-2:0] sat_t(input logic signed [TW-1:0] t);
    return (t[TW-1:CW-1] != '0) ? '1 : t[CW-2:0];
  endfunction

  logic [1:0]             vld;
  logic                   skid_full;
  logic signed [TW-1:0]   bx, sx, u0, u1, epsx;
  logic signed [TW-1:0]   t0_1, t1_1, t0_2, t1_2;
  logic                   h0_1, h1_1, h0_2, h1_2;
  logic signed [CW-1:0]   o_1 [3];
  logic signed [CW-1:0]   o_2 [3];
  logic signed [DW-1:0]   d_1 [3];
  logic signed [PTW-1:0]  p0_2 [3];
  logic signed [PTW-1:0]  p1_2 [3];
  logic signed [HW-1:0]   q0, q1;
  logic [CW-1:0]          s0 [3];
  logic [CW-1:0]          s1 [3];
  logic [1:0]             n_cnt, k_cnt;
  logic [CW-2:0]          n_nt, n_ft, k_nt, k_ft;
  logic signed [CW-1:0]   n_np [3];
  logic signed [CW-1:0]   n_fp [3];
  logic signed [CW-1:0]   k_np [3];
  logic signed [CW-1:0]   k_fp [3];

  assign adv = !skid_full;

  always_comb begin
    bx   = TW'(b);
    sx   = TW'({1'b0, s});
    u0   = -bx - sx;
    u1   = -bx + sx;
    epsx = TW'({1'b0, eps});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t0_1 <= u0 >>> 1;
      t1_1 <= u1 >>> 1;
      h0_1 <= !miss && ((u0 >>> 1) > epsx);
      h1_1 <= !miss && ((u1 >>> 1) > epsx);
      o_1  <= org;
      d_1  <= dir;
      for (int i = 0; i < 3; i++) begin
        p0_2[i] <= d_1[i] * t0_1;
        p1_2[i] <= d_1[i] * t1_1;
      end
      t0_2 <= t0_1;
      t1_2 <= t1_1;
      h0_2 <= h0_1;
      h1_2 <= h1_1;
      o_2  <= o_1;
    end
  end

  always_comb begin
    q0 = '0;
    q1 = '0;
    for (int i = 0; i < 3; i++) begin
      q0    = HW'(o_2[i]) + HW'(p0_2[i] >>> FB);
      q1    = HW'(o_2[i]) + HW'(p1_2[i] >>> FB);
      s0[i] = sat_c(q0);
      s1[i] = sat_c(q1);
    end
    n_cnt = {1'b0, h0_2} + {1'b0, h1_2};
    n_nt  = '0;
    n_ft  = '0;
    for (int i = 0; i < 3; i++) begin
      n_np[i] = '0;
      n_fp[i] = '0;
    end
    if (h0_2) begin
      n_nt = sat_t(t0_2);
      for (int i = 0; i < 3; i++) n_np[i] = s0[i];
      if (h1_2) begin
        n_ft = sat_t(t1_2);
        for (int i = 0; i < 3; i++) n_fp[i] = s1[i];
      end
    end else if (h1_2) begin
      n_nt = sat_t(t1_2);
      for (int i = 0; i < 3; i++) n_np[i] = s1[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (!out_stall) begin
        skid_full <= 1'b0;
      end
    end else if (!out_valid || !out_stall) begin
      out_valid <= vld[1];
    end else if (vld[1]) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (!out_stall) begin
        cnt <= k_cnt;
        nt  <= k_nt;
        ft  <= k_ft;
        np  <= k_np;
        fp  <= k_fp;
      end
    end else if (!out_valid || !out_stall) begin
      cnt <= n_cnt;
      nt  <= n_nt;
      ft  <= n_ft;
      np  <= n_np;
      fp  <= n_fp;
    end else begin
      k_cnt <= n_cnt;
      k_nt  <= n_nt;
      k_ft  <= n_ft;
      k_np  <= n_np;
      k_fp  <= n_fp;
    end
  end

endmodule

@@ src/ray_sphere_intersect_unit.sv @@
// ----------------------------------------------------------------------------
// ray_sphere_intersect_unit
// Intersects one ray per transaction with a configured sphere and returns
// up to two hits, nearest first, with distance and hit point. Fully
// pipelined: a new ray is taken every cycle while in_stall is low. The
// path is 6 front-end stages, one square-root stage per root bit
// (DISCW/2, 39 at the default formats), and 3 back-end stages, so 48
// register stages at the defaults. Most of these stages belong to the
// square-root pipeline, which resolves one root bit per stage. While a
// result waits, the pipeline keeps advancing over empty slots. The next
// result then goes into a one-entry skid buffer behind the output
// register, and in_stall rises until the waiting result is taken.
// Configuration writes must only happen while no ray is in flight.
// ----------------------------------------------------------------------------
module ray_sphere_intersect_unit #(
  parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH,
  parameter int FRAC_BITS   = rsi_pkg::FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [rsi_pkg::REG_IDX_WIDTH-1:0]   cfg_index,
  input  logic [((2*COORD_WIDTH-1 > 63) ? 63 : 2*COORD_WIDTH-1)-1:0] cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [COORD_WIDTH-1:0]       origin_x,
  input  logic signed [COORD_WIDTH-1:0]       origin_y,
  input  logic signed [COORD_WIDTH-1:0]       origin_z,
  input  logic signed [FRAC_BITS+1:0]         dir_x,
  input  logic signed [FRAC_BITS+1:0]         dir_y,
  input  logic signed [FRAC_BITS+1:0]         dir_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          hit_count,
  output logic [COORD_WIDTH-2:0]              near_t,
  output logic signed [COORD_WIDTH-1:0]       near_x,
  output logic signed [COORD_WIDTH-1:0]       near_y,
  output logic signed [COORD_WIDTH-1:0]       near_z,
  output logic [COORD_WIDTH-2:0]              far_t,
  output logic signed [COORD_WIDTH-1:0]       far_x,
  output logic signed [COORD_WIDTH-1:0]       far_y,
  output logic signed [COORD_WIDTH-1:0]       far_z
);

  localparam int CW    = COORD_WIDTH;
  localparam int FB    = FRAC_BITS;
  localparam int EW    = rsi_pkg::EPS_WIDTH;
  localparam int DW    = FB + 2;
  localparam int VW    = CW + 1;
  localparam int PDW   = DW + VW;
  localparam int DOTW  = PDW + 2;
  localparam int BW    = DOTW - FB + 1;
  localparam int PVW   = 2 * VW;
  localparam int VVW   = PVW + 2;
  localparam int RW    = (2*CW-1 > 63) ? 63 : 2*CW-1;
  localparam int CCW   = ((VVW > RW + 1) ? VVW : RW + 1) + 1;
  localparam int H     = (BW + 1) / 2;
  localparam int BBW   = 4 * H;
  localparam int DISCW = ((BBW + 1 > CCW + 2) ? BBW + 1 : CCW + 2) + 1;
  localparam int RDW   = DISCW - 1;
  localparam int SQW   = DISCW / 2;
  localparam int TW    = ((BW > SQW + 1) ? BW : SQW + 1) + 1;
  localparam int SBW   = BW + 1 + 3*CW + 3*DW;

  logic signed [CW-1:0]  ctr [3];
  logic [RW-1:0]         rsq;
  logic [EW-1:0]         eps;
  logic                  adv;

  logic signed [CW-1:0]  org_in [3];
  logic signed [DW-1:0]  dir_in [3];

  logic                  q_valid, q_miss;
  logic [RDW-1:0]        q_rad;
  logic signed [BW-1:0]  q_b;
  logic signed [CW-1:0]  q_org [3];
  logic signed [DW-1:0]  q_dir [3];
  logic [SBW-1:0]        q_sb;

  logic                  r_valid;
  logic [SQW-1:0]        r_root;
  logic [SBW-1:0]        r_sb;
  logic signed [BW-1:0]  r_b;
  logic                  r_miss;
  logic signed [CW-1:0]  r_org [3];
  logic signed [DW-1:0]  r_dir [3];

  logic signed [CW-1:0]  np [3];
  logic signed [CW-1:0]  fp [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctr[0] <= '0;
      ctr[1] <= '0;
      ctr[2] <= '0;
      rsq    <= RW'(1) << (2*FB);
      eps    <= EW'(1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        rsi_pkg::REG_CENTER_X:  ctr[0] <= cfg_data[CW-1:0];
        rsi_pkg::REG_CENTER_Y:  ctr[1] <= cfg_data[CW-1:0];
        rsi_pkg::REG_CENTER_Z:  ctr[2] <= cfg_data[CW-1:0];
        rsi_pkg::REG_RADIUS_SQ: rsq    <= cfg_data;
        rsi_pkg::REG_EPSILON:   eps    <= cfg_data[EW-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall  = !adv;
  assign org_in[0] = origin_x;
  assign org_in[1] = origin_y;
  assign org_in[2] = origin_z;
  assign dir_in[0] = dir_x;
  assign dir_in[1] = dir_y;
  assign dir_in[2] = dir_z;

  rsi_quad #(
    .CW(CW), .FB(FB), .DW(DW), .VW(VW), .PDW(PDW), .DOTW(DOTW), .BW(BW),
    .PVW(PVW), .VVW(VVW), .RW(RW), .CCW(CCW), .H(H), .BBW(BBW), .DISCW(DISCW)
  ) u_quad (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (in_valid),
    .org       (org_in),
    .dir       (dir_in),
    .ctr       (ctr),
    .rsq       (rsq),
    .eps       (eps),
    .out_valid (q_valid),
    .rad       (q_rad),
    .miss      (q_miss),
    .b_out     (q_b),
    .org_out   (q_org),
    .dir_out   (q_dir)
  );

  assign q_sb = {q_b, q_miss, q_org[0], q_org[1], q_org[2],
                 q_dir[0], q_dir[1], q_dir[2]};

  rsi_sqrt #(
    .RDW(RDW), .SQW(SQW), .SBW(SBW)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (q_valid),
    .rad       (q_rad),
    .sb_in     (q_sb),
    .out_valid (r_valid),
    .root      (r_root),
    .sb_out    (r_sb)
  );

  assign {r_b, r_miss, r_org[0], r_org[1], r_org[2],
          r_dir[0], r_dir[1], r_dir[2]} = r_sb;

  rsi_hit #(
    .CW(CW), .FB(FB), .DW(DW), .BW(BW), .SQW(SQW), .TW(TW)
  ) u_hit (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (r_valid),
    .b         (r_b),
    .s         (r_root),
    .miss      (r_miss),
    .org       (r_org),
    .dir       (r_dir),
    .eps       (eps),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cnt       (hit_count),
    .nt        (near_t),
    .np        (np),
    .ft        (far_t),
    .fp        (fp)
  );

  assign near_x = np[0];
  assign near_y = np[1];
  assign near_z = np[2];
  assign far_x  = fp[0];
  assign far_y  = fp[1];
  assign far_z  = fp[2];

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> hit_count != 2'd3)
    else $error("hit_count out of range");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit_count == 2'd0 |-> near_t == '0 && near_x == '0 && far_t == '0)
    else $error("miss result not zero");

  a_far_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit_count != 2'd2 |-> far_t == '0 && far_x == '0 && far_z == '0)
    else $error("unused far slot not zero");

  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit_count == 2'd2 |-> near_t <= far_t)
    else $error("hits not nearest first");

  a_skid_has_out: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");
`endif

endmodule
